/* hdl/rmg_pkg.sv */
// Shared constants and types for the running-maximum grey-level converter.
`default_nettype none
package rmg_pkg;

    // Pixel and result geometry.
    localparam int PIXEL_BITS = 16;
    localparam int GRAY_BITS  = 8;
    localparam int DVD_BITS   = PIXEL_BITS + GRAY_BITS;
    localparam int STEP_BITS  = $clog2(GRAY_BITS);

    // Frame geometry and pixel counting.
    localparam int DIM_BITS    = 10;
    localparam int MAX_PIXELS  = 262144;
    localparam int COUNT_BITS  = $clog2(MAX_PIXELS + 1);
    localparam int CMP_BITS    = (COUNT_BITS > 2 * DIM_BITS) ? COUNT_BITS : 2 * DIM_BITS;
    localparam int DIM_RESET   = 256;

    // Configuration register indexes.
    localparam logic CFG_FRAME_WIDTH  = 1'b0;
    localparam logic CFG_FRAME_HEIGHT = 1'b1;

    // Divider sequencer states.
    typedef enum logic {
        DIV_IDLE,
        DIV_RUN
    } t_div_state;

    // Control from the top level to the divider.
    typedef struct packed {
        logic start;
        logic stall;
    } t_div_ctl;

    // Status from the divider to the top level.
    typedef struct packed {
        logic busy;
        logic last_step;
    } t_div_sts;

    // Per-pixel result of the frame bookkeeping.
    typedef struct packed {
        logic [PIXEL_BITS-1:0] peak;
        logic                  mismatch;
    } t_frame_res;

endpackage
`default_nettype wire

/* hdl/running_max_gray16_to_gray8.sv */
// Top level: normalises 16-bit grey pixels to 8 bits against the frame's running peak.
// Each pixel is accepted, which updates the peak and count, and then goes through the
// eight steps of the bit-serial divider, one quotient bit per cycle unless the output stalls.
// Input ready stays low while the divider is busy, so a new pixel is taken only once
// the previous one has finished the divider's eight steps.
// Reset (synchronous, active low) clears the peak, the count and both handshakes,
// and sets width and height to 256.
`default_nettype none
module running_max_gray16_to_gray8 (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // Configuration write port.
    input  wire         i_cfg_we,
    input  wire         i_cfg_index,
    input  wire  [9:0]  i_cfg_data,
    // Input stream.
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [15:0] s_axis_tdata,   // [15:0] pixel_value
    input  wire         s_axis_tlast,
    // Output stream.
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] gray_value
    output logic        m_axis_tlast,
    output logic        m_axis_tuser    // [0] size_mismatch
);

    logic                               accept;
    logic [rmg_pkg::PIXEL_BITS-1:0]     pixel;
    logic [rmg_pkg::DVD_BITS-1:0]       dividend;
    rmg_pkg::t_frame_res                frame_res;
    rmg_pkg::t_div_ctl                  div_ctl;
    rmg_pkg::t_div_sts                  div_sts;
    logic [rmg_pkg::GRAY_BITS-1:0]      quot_next;
    logic                               out_load;

    logic                               r_pend_last;
    logic                               r_pend_mis;
    logic                               r_pend_zero;
    logic                               r_out_valid;
    logic [rmg_pkg::GRAY_BITS-1:0]      r_out_gray;
    logic                               r_out_last;
    logic                               r_out_mis;

    // Input transfer and the pixel times 255 as a shift and subtract.
    always_comb begin
        s_axis_tready = i_rst_n && !div_sts.busy;
        accept        = s_axis_tvalid && s_axis_tready;
        pixel         = s_axis_tdata[rmg_pkg::PIXEL_BITS-1:0];
        dividend      = {pixel, rmg_pkg::GRAY_BITS'(0)} - rmg_pkg::DVD_BITS'(pixel);
    end

    rmg_frame u_frame (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .i_pixel     (pixel),
        .i_last      (s_axis_tlast),
        .o_res       (frame_res)
    );

    // The divider holds its current step while a result is still unclaimed.
    always_comb begin
        div_ctl.start = accept;
        div_ctl.stall = r_out_valid && !m_axis_tready;
        out_load      = div_sts.last_step;
    end

    rmg_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (div_ctl),
        .i_dividend  (dividend),
        .i_divisor   (frame_res.peak),
        .o_sts       (div_sts),
        .o_quot_next (quot_next)
    );

    // Side information travels with the pixel while it is in the divider.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pend_last <= s_axis_tlast;
            r_pend_mis  <= frame_res.mismatch;
            r_pend_zero <= (frame_res.peak == '0);
        end
    end

    // Output register: a zero peak gives a grey value of zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_gray <= r_pend_zero ? '0 : quot_next;
            r_out_last <= r_pend_last;
            r_out_mis  <= r_pend_mis;
        end
    end

    always_comb begin
        m_axis_tvalid = r_out_valid;
        m_axis_tdata  = r_out_gray;
        m_axis_tlast  = r_out_last;
        m_axis_tuser  = r_out_mis;
    end

endmodule
`default_nettype wire

/* hdl/rmg_frame.sv */
// Frame bookkeeping: geometry registers, running peak and pixel count.
`default_nettype none
module rmg_frame (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_cfg_we,
    input  wire                              i_cfg_index,
    input  wire  [rmg_pkg::DIM_BITS-1:0]     i_cfg_data,
    input  wire                              i_accept,
    input  wire  [rmg_pkg::PIXEL_BITS-1:0]   i_pixel,
    input  wire                              i_last,
    output rmg_pkg::t_frame_res              o_res
);

    logic [rmg_pkg::DIM_BITS-1:0]   r_width;
    logic [rmg_pkg::DIM_BITS-1:0]   r_height;
    logic [rmg_pkg::PIXEL_BITS-1:0] r_peak;
    logic [rmg_pkg::PIXEL_BITS-1:0] n_peak;
    logic [rmg_pkg::COUNT_BITS-1:0] r_count;
    logic [rmg_pkg::COUNT_BITS-1:0] n_count;
    logic [rmg_pkg::CMP_BITS-1:0]   expected;

    // The peak includes the current pixel; the count saturates at the maximum.
    always_comb begin
        n_peak = (i_pixel > r_peak) ? i_pixel : r_peak;
        if (r_count < rmg_pkg::COUNT_BITS'(rmg_pkg::MAX_PIXELS)) begin
            n_count = r_count + rmg_pkg::COUNT_BITS'(1);
        end else begin
            n_count = r_count;
        end
        expected = rmg_pkg::CMP_BITS'(r_width) * rmg_pkg::CMP_BITS'(r_height);
    end

    // The mismatch flag is only raised on the last pixel of a frame.
    always_comb begin
        o_res.peak     = n_peak;
        o_res.mismatch = i_last && (rmg_pkg::CMP_BITS'(n_count) != expected);
    end

    // Geometry registers are written through the configuration port.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= rmg_pkg::DIM_BITS'(rmg_pkg::DIM_RESET);
            r_height <= rmg_pkg::DIM_BITS'(rmg_pkg::DIM_RESET);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                rmg_pkg::CFG_FRAME_WIDTH:  r_width  <= i_cfg_data;
                rmg_pkg::CFG_FRAME_HEIGHT: r_height <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Running state is cleared after the last pixel of each frame.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_peak  <= '0;
            r_count <= '0;
        end else if (i_accept) begin
            if (i_last) begin
                r_peak  <= '0;
                r_count <= '0;
            end else begin
                r_peak  <= n_peak;
                r_count <= n_count;
            end
        end
    end

endmodule
`default_nettype wire

/* hdl/rmg_div.sv */
// Bit-serial restoring divider producing one quotient bit per cycle while not stalled.
`default_nettype none
module rmg_div (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire  rmg_pkg::t_div_ctl          i_ctl,
    input  wire  [rmg_pkg::DVD_BITS-1:0]     i_dividend,
    input  wire  [rmg_pkg::PIXEL_BITS-1:0]   i_divisor,
    output rmg_pkg::t_div_sts                o_sts,
    output logic [rmg_pkg::GRAY_BITS-1:0]    o_quot_next
);

    rmg_pkg::t_div_state r_state;
    rmg_pkg::t_div_state n_state;

    logic [rmg_pkg::PIXEL_BITS-1:0] r_rem;
    logic [rmg_pkg::PIXEL_BITS-1:0] n_rem;
    logic [rmg_pkg::GRAY_BITS-1:0]  r_low;
    logic [rmg_pkg::GRAY_BITS-1:0]  r_quot;
    logic [rmg_pkg::PIXEL_BITS-1:0] r_div;
    logic [rmg_pkg::STEP_BITS-1:0]  r_step;
    logic [rmg_pkg::PIXEL_BITS:0]   trial;
    logic [rmg_pkg::PIXEL_BITS:0]   diff;
    logic                           q_bit;
    logic                           stepping;

    // One restoring step: bring down the next dividend bit and try a subtract.
    always_comb begin
        trial = {r_rem, r_low[rmg_pkg::GRAY_BITS-1]};
        diff  = trial - {1'b0, r_div};
        q_bit = !diff[rmg_pkg::PIXEL_BITS];
        if (q_bit) begin
            n_rem = diff[rmg_pkg::PIXEL_BITS-1:0];
        end else begin
            n_rem = trial[rmg_pkg::PIXEL_BITS-1:0];
        end
        o_quot_next = {r_quot[rmg_pkg::GRAY_BITS-2:0], q_bit};
    end

    // Next state of the sequencer.
    always_comb begin
        n_state = r_state;
        case (r_state)
            rmg_pkg::DIV_IDLE: begin
                if (i_ctl.start) begin
                    n_state = rmg_pkg::DIV_RUN;
                end
            end
            rmg_pkg::DIV_RUN: begin
                if (!i_ctl.stall && (r_step == rmg_pkg::STEP_BITS'(rmg_pkg::GRAY_BITS - 1))) begin
                    n_state = rmg_pkg::DIV_IDLE;
                end
            end
            default: n_state = rmg_pkg::DIV_IDLE;
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        stepping        = 1'b0;
        o_sts.busy      = 1'b0;
        o_sts.last_step = 1'b0;
        case (r_state)
            rmg_pkg::DIV_IDLE: begin
            end
            rmg_pkg::DIV_RUN: begin
                o_sts.busy      = 1'b1;
                stepping        = !i_ctl.stall;
                o_sts.last_step = !i_ctl.stall &&
                    (r_step == rmg_pkg::STEP_BITS'(rmg_pkg::GRAY_BITS - 1));
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rmg_pkg::DIV_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            if (i_ctl.start) begin
                r_step <= '0;
            end else if (stepping) begin
                r_step <= r_step + rmg_pkg::STEP_BITS'(1);
            end
        end
    end

    // Datapath: the upper dividend bits seed the remainder, the low byte shifts in.
    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_rem  <= i_dividend[rmg_pkg::DVD_BITS-1:rmg_pkg::GRAY_BITS];
            r_low  <= i_dividend[rmg_pkg::GRAY_BITS-1:0];
            r_div  <= i_divisor;
            r_quot <= '0;
        end else if (stepping) begin
            r_rem  <= n_rem;
            r_low  <= {r_low[rmg_pkg::GRAY_BITS-2:0], 1'b0};
            r_quot <= o_quot_next;
        end
    end

endmodule
`default_nettype wire

/* dv/running_max_gray16_to_gray8_tb.sv */
// Self-checking testbench for the running-maximum 16-to-8-bit grey-level converter.
`timescale 1ns / 1ps
module running_max_gray16_to_gray8_tb;

    localparam int DRAIN_CYCLES = 12;
    localparam int STUCK_LIMIT  = 4000;
    localparam int HOLD_CYCLES  = 300;
    localparam int GRAY_FULL    = 255;

    // One expected output transfer.
    typedef struct packed {
        logic [rmg_pkg::GRAY_BITS-1:0] gray;
        logic                          frame_end;
        logic                          mismatch;
    } t_gray_result;

    // How the pixels of a frame are drawn.
    typedef enum int {
        PIX_RANDOM,
        PIX_DIM,
        PIX_ZERO_LEAD,
        PIX_RAMP,
        PIX_BRIGHT,
        PIX_ONE_HOT
    } t_pixel_style;

    logic                           i_clk         = 1'b0;
    logic                           i_rst_n       = 1'b0;
    logic                           i_cfg_we      = 1'b0;
    logic                           i_cfg_index   = rmg_pkg::CFG_FRAME_WIDTH;
    logic [rmg_pkg::DIM_BITS-1:0]   i_cfg_data    = '0;
    logic                           s_axis_tvalid = 1'b0;
    logic                           s_axis_tready;
    logic [rmg_pkg::PIXEL_BITS-1:0] s_axis_tdata  = '0;
    logic                           s_axis_tlast  = 1'b0;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready = 1'b0;
    logic [rmg_pkg::GRAY_BITS-1:0]  m_axis_tdata;
    logic                           m_axis_tlast;
    logic                           m_axis_tuser;

    // Predictor state: the block's registers and frame bookkeeping.
    logic [rmg_pkg::DIM_BITS-1:0]   frame_width_q  = rmg_pkg::DIM_BITS'(rmg_pkg::DIM_RESET);
    logic [rmg_pkg::DIM_BITS-1:0]   frame_height_q = rmg_pkg::DIM_BITS'(rmg_pkg::DIM_RESET);
    logic [rmg_pkg::PIXEL_BITS-1:0] peak_q         = '0;
    int                             pixel_count_q  = 0;

    t_gray_result gray_expect_q[$];

    int send_idle_pct   = 0;
    int recv_stall_pct  = 0;
    int hold_request    = 0;
    int hold_left       = 0;
    int stuck_cycles    = 0;
    int error_count     = 0;
    int pixels_sent     = 0;
    int frames_sent     = 0;
    int results_checked = 0;

    running_max_gray16_to_gray8 u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // [15:0] pixel_value
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // [7:0] gray_value
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)    // [0] size_mismatch
    );

    // 20 ns clock.
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Works out the result of one accepted pixel and advances the frame state.
    function automatic t_gray_result normalise_pixel(
            input logic [rmg_pkg::PIXEL_BITS-1:0] pix,
            input logic last);
        t_gray_result res;
        int unsigned  quotient;
        res = '0;
        if (pix > peak_q)
            peak_q = pix;
        if (peak_q != '0) begin
            quotient = (int'(pix) * GRAY_FULL) / int'(peak_q);
            res.gray = (quotient > GRAY_FULL) ? rmg_pkg::GRAY_BITS'(GRAY_FULL)
                                              : rmg_pkg::GRAY_BITS'(quotient);
        end
        if (pixel_count_q < rmg_pkg::MAX_PIXELS)
            pixel_count_q++;
        res.frame_end = last;
        if (last) begin
            res.mismatch  = (pixel_count_q != int'(frame_width_q) * int'(frame_height_q));
            peak_q        = '0;
            pixel_count_q = 0;
        end
        return res;
    endfunction

    // Prints one line per mismatch and counts them all.
    task automatic report_mismatch(input string what, input int want, input int got);
        error_count++;
        $display("ERROR at %0t ns: %s expected %0d, got %0d", $time, what, want, got);
    endtask

    // Compares one output transfer with the oldest pending expectation.
    task automatic check_result();
        t_gray_result want;
        if (gray_expect_q.size() == 0) begin
            report_mismatch("output transfer with nothing pending, gray_value", -1,
                            m_axis_tdata);
            return;
        end
        want = gray_expect_q.pop_front();
        results_checked++;
        if (m_axis_tdata !== want.gray)
            report_mismatch("gray_value", want.gray, m_axis_tdata);
        if (m_axis_tlast !== want.frame_end)
            report_mismatch("frame_end", want.frame_end, m_axis_tlast);
        if (m_axis_tuser !== want.mismatch)
            report_mismatch("size_mismatch", want.mismatch, m_axis_tuser);
    endtask

    // Output monitor.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            check_result();
    end

    // Receiver: random stalls, or a long hold-off when one is requested.
    always @(posedge i_clk) begin
        if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            m_axis_tready <= 1'b0;
            hold_left--;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog: ends the run when neither side has moved for too long.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles >= STUCK_LIMIT) begin
            $display("Watchdog expired at %0t ns with %0d results pending.", $time,
                     gray_expect_q.size());
            $display("running_max_gray16_to_gray8 regression: fail");
            $finish;
        end
    end

    // Offers one pixel and waits for its transfer. Valid is left high so that
    // back-to-back pixels need no gap; it is lowered only for idle cycles.
    task automatic send_pixel(input logic [rmg_pkg::PIXEL_BITS-1:0] pix, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pix;
        s_axis_tlast  <= last;
        do
            @(posedge i_clk);
        while (!s_axis_tready);
        gray_expect_q.push_back(normalise_pixel(pix, last));
        pixels_sent++;
    endtask

    function automatic logic [rmg_pkg::PIXEL_BITS-1:0] pick_pixel(
            input t_pixel_style style, input int idx, input int len);
        logic [rmg_pkg::PIXEL_BITS-1:0] pix;
        case (style)
            PIX_DIM:       pix = rmg_pkg::PIXEL_BITS'($urandom_range(15));
            PIX_ZERO_LEAD: pix = (idx < len / 2) ? '0
                                 : rmg_pkg::PIXEL_BITS'($urandom_range(65535));
            PIX_RAMP:      pix = rmg_pkg::PIXEL_BITS'(((idx + 1) * 65535) / len);
            PIX_BRIGHT:    pix = rmg_pkg::PIXEL_BITS'($urandom_range(65535, 65235));
            PIX_ONE_HOT: begin
                pix = rmg_pkg::PIXEL_BITS'(1) << $urandom_range(rmg_pkg::PIXEL_BITS - 1);
                if ($urandom_range(1))
                    pix = ~pix;
            end
            default:       pix = rmg_pkg::PIXEL_BITS'($urandom_range(65535));
        endcase
        return pix;
    endfunction

    // Sends a frame of len pixels with the last one flagged.
    task automatic send_frame(input int len, input t_pixel_style style);
        for (int i = 0; i < len; i++)
            send_pixel(pick_pixel(style, i, len), i == len - 1);
        frames_sent++;
    endtask

    // Stops offering pixels and waits until every result has come back.
    task automatic drain_pipeline();
        s_axis_tvalid <= 1'b0;
        while (gray_expect_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Writes both geometry registers while the block is idle.
    task automatic set_geometry(input logic [rmg_pkg::DIM_BITS-1:0] width,
                                input logic [rmg_pkg::DIM_BITS-1:0] height);
        drain_pipeline();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= rmg_pkg::CFG_FRAME_WIDTH;
        i_cfg_data  <= width;
        @(posedge i_clk);
        frame_width_q = width;
        i_cfg_index <= rmg_pkg::CFG_FRAME_HEIGHT;
        i_cfg_data  <= height;
        @(posedge i_clk);
        frame_height_q = height;
        i_cfg_we <= 1'b0;
    endtask

    // Zero peak: pixels of value 0 before and after a non-zero one, under the
    // reset geometry, and a one-pixel frame of value 0.
    task automatic test_zero_peak();
        send_pixel(16'h0000, 1'b0);
        send_pixel(16'h0000, 1'b0);
        send_pixel(16'h0000, 1'b0);
        send_pixel(16'd40000, 1'b0);
        send_pixel(16'h0000, 1'b0);
        send_pixel(16'hFFFF, 1'b0);
        send_pixel(16'h0001, 1'b1);
        send_pixel(16'h0000, 1'b1);
        frames_sent += 2;
    endtask

    // Frame size check: a matching frame, a short one and a one-pixel frame.
    task automatic test_frame_size_check();
        set_geometry(10'd2, 10'd3);
        send_pixel(16'h0001, 1'b0);
        send_pixel(16'h0002, 1'b0);
        send_pixel(16'h0004, 1'b0);
        send_pixel(16'h8000, 1'b0);
        send_pixel(16'hFFFF, 1'b0);
        send_pixel(16'h7FFF, 1'b1);
        send_frame(5, PIX_RAMP);
        set_geometry(10'd1, 10'd1);
        send_pixel(16'hAAAA, 1'b1);
        frames_sent += 2;
    endtask

    // Zero, oversized and largest legal geometry, then full frames at the
    // widest and tallest shapes.
    task automatic test_geometry_extremes();
        set_geometry(10'd0, 10'd5);
        send_pixel(16'h5555, 1'b1);
        frames_sent++;
        set_geometry(10'd1023, 10'd1023);
        send_frame(2, PIX_ONE_HOT);
        set_geometry(10'd512, 10'd512);
        send_frame(2, PIX_BRIGHT);
        set_geometry(10'd512, 10'd1);
        send_frame(512, PIX_RANDOM);
        set_geometry(10'd1, 10'd512);
        send_frame(512, PIX_ZERO_LEAD);
    endtask

    // Random frames, mostly of the configured size, under one idling setting.
    task automatic test_random_frames(input int idle_pct, input int stall_pct,
                                      input int budget);
        int sent;
        int width;
        int height;
        int area;
        int len;
        sent           = 0;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        while (sent < budget) begin
            width  = $urandom_range(8, 1);
            height = $urandom_range(8, 1);
            case ($urandom_range(19))
                0: width = 0;
                1: height = 1023;
                2: width = $urandom_range(64, 9);
                default: ;
            endcase
            set_geometry(rmg_pkg::DIM_BITS'(width), rmg_pkg::DIM_BITS'(height));
            area = width * height;
            repeat ($urandom_range(5, 2)) begin
                case ($urandom_range(9))
                    0: len = (area > 1) ? area - 1 : 1;
                    1: len = area + $urandom_range(3, 1);
                    2: len = $urandom_range(12, 1);
                    default: len = (area >= 1 && area <= 512) ? area : $urandom_range(12, 1);
                endcase
                send_frame(len, t_pixel_style'($urandom_range(5)));
                sent += len;
            end
        end
        drain_pipeline();
    endtask

    // The receiver holds off while pixels keep coming, so the input stalls.
    task automatic test_output_backpressure();
        set_geometry(10'd8, 10'd5);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_request   = HOLD_CYCLES;
        send_frame(40, PIX_RANDOM);
        drain_pipeline();
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_zero_peak();
        test_frame_size_check();
        test_geometry_extremes();
        test_random_frames(0, 0, 100);
        test_random_frames(59, 0, 100);
        test_random_frames(0, 59, 100);
        test_random_frames(33, 33, 100);
        test_output_backpressure();

        drain_pipeline();
        repeat (20) @(posedge i_clk);
        $display("Sent %0d pixels in %0d frames and checked %0d results.",
                 pixels_sent, frames_sent, results_checked);
        $display("Covered zero peaks, size checks, extreme geometry, four idling mixes "
                 , "and a long output hold.");
        if (error_count == 0)
            $display("running_max_gray16_to_gray8 regression: pass");
        else
            $display("running_max_gray16_to_gray8 regression: fail");
        $finish;
    end

endmodule

/* filelist.f */
hdl/rmg_pkg.sv
hdl/rmg_frame.sv
hdl/rmg_div.sv
hdl/running_max_gray16_to_gray8.sv
dv/running_max_gray16_to_gray8_tb.sv
